[src/skg_pkg.sv]
// Package for the sorted key group table: beat types, codes and sequencer states.
`default_nettype none

package skg_pkg;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  localparam logic [2:0] ST_NEW     = 3'd0;
  localparam logic [2:0] ST_JOIN    = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_PRESENT = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

  typedef struct packed {
    logic               func;
    logic [5:0]         species_index;
    logic signed [31:0] key_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  level_position;
    logic [4:0]  level_count;
    logic [63:0] level_members;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DECIDE,
    S_SH_RD,
    S_SH_WR,
    S_INS,
    S_FIN
  } state_e;

endpackage

`default_nettype wire

[src/sorted_key_group_table.sv]
// Sorted key group table: ascending keyed levels with species masks, one shared compare unit.
//
// Input channel in_valid_i / in_stall_o / in_data_i carries one beat per item: insert a
// species at a signed Q16.16 key, or clear the whole table. Output channel out_valid_o /
// out_stall_i / out_data_o returns exactly one result beat per item.
// A beat moves when valid is high and stall is low.
// Keys and masks sit in two single-port-style memories (one read, one write per cycle,
// registered read). A sequencer walks the stored levels through one signed compare unit.
// Steps per item, with U levels held and P the sorted position:
//   clear or species out of range: accept, hand-over to the output register;
//   insert: accept, scan of U levels, decide, move up of levels P to U-1, insert, hand-over.
// The scan reads the stored levels through the read port in turn; a join or a full
// table skips the move up and insert, and a species found ends the scan early.
// in_stall_o is low only while the sequencer is idle; a new item may be taken while the
// previous result still waits in the output register.
// When the receiver stalls, the finished result waits in the sequencer until the output
// register frees up, and the beat on the output holds.
// Reset empties the table (level count zero, no output pending); no clearing pass is
// needed, as only levels below the count are ever read.
`default_nettype none

module sorted_key_group_table
  import skg_pkg::*;
#(
  parameter int LEVELS  = 16,
  parameter int SPECIES = 64
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o
);

  localparam int CW = $clog2(LEVELS + 1);
  localparam int IW = $clog2(LEVELS);

  function automatic out_item_t pack_res(logic [2:0] st, logic [CW-1:0] p,
                                         logic [CW-1:0] c, logic [SPECIES-1:0] m);
    logic [31:0] pe;
    logic [31:0] ce;
    out_item_t   r;
    pe = 32'(p);
    ce = 32'(c);
    r.status         = st;
    r.level_position = pe[3:0];
    r.level_count    = ce[4:0];
    r.level_members  = 64'(m);
    return r;
  endfunction

  state_e state_q, state_d;

  logic signed [31:0] key_q, key_d;
  logic [SPECIES-1:0] bit_q, bit_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      pos_q, pos_d;
  logic               found_q, found_d;
  logic               eq_q, eq_d;
  logic [SPECIES-1:0] posmask_q, posmask_d;
  logic [CW-1:0]      used_q, used_d;
  out_item_t          res_q, res_d;
  out_item_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic signed [31:0] key_mem [LEVELS];
  logic [SPECIES-1:0] mask_mem [LEVELS];
  logic signed [31:0] rd_key_q;
  logic [SPECIES-1:0] rd_mask_q;
  logic [IW-1:0]      rd_addr;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic signed [31:0] wr_key;
  logic [SPECIES-1:0] wr_mask;

  logic               in_take;
  logic               out_free;
  logic               sp_bad;
  logic [63:0]        onehot;
  logic [CW-1:0]      idx_inc;
  logic [CW-1:0]      idx_dec;
  logic               cmp_ge;
  logic               cmp_eq;
  logic               hit;
  logic               last_lvl;
  logic               tbl_full;
  logic [SPECIES-1:0] join_mask;

  // shared compare unit
  assign cmp_ge    = rd_key_q >= key_q;
  assign cmp_eq    = rd_key_q == key_q;

  assign in_stall_o = state_q != S_IDLE;
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign sp_bad     = {1'b0, in_data_i.species_index} >= 7'(SPECIES);
  assign onehot     = 64'(1) << in_data_i.species_index;
  assign idx_inc    = idx_q + CW'(1);
  assign idx_dec    = idx_q - CW'(1);
  assign hit        = |(rd_mask_q & bit_q);
  assign last_lvl   = idx_inc == used_q;
  assign tbl_full   = used_q == CW'(LEVELS);
  assign join_mask  = posmask_q | bit_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          if (in_data_i.func == FUNC_CLEAR || sp_bad) begin
            state_d = S_FIN;
          end else if (used_q == '0) begin
            state_d = S_DECIDE;
          end else begin
            state_d = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD:  state_d = S_SCAN_CHK;
      S_SCAN_CHK: begin
        priority if (hit) begin
          state_d = S_FIN;
        end else if (last_lvl) begin
          state_d = S_DECIDE;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_DECIDE: begin
        priority if ((found_q && eq_q) || tbl_full) begin
          state_d = S_FIN;
        end else if (used_q == pos_q) begin
          state_d = S_INS;
        end else begin
          state_d = S_SH_RD;
        end
      end
      S_SH_RD: state_d = S_SH_WR;
      S_SH_WR: state_d = (idx_dec == pos_q) ? S_INS : S_SH_RD;
      S_INS:   state_d = S_FIN;
      S_FIN:   state_d = out_free ? S_IDLE : S_FIN;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    key_d       = key_q;
    bit_d       = bit_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    found_d     = found_q;
    eq_d        = eq_q;
    posmask_d   = posmask_q;
    used_d      = used_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_addr     = idx_q[IW-1:0];
    wr_en       = 1'b0;
    wr_addr     = pos_q[IW-1:0];
    wr_key      = key_q;
    wr_mask     = bit_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          key_d   = in_data_i.key_value;
          bit_d   = onehot[SPECIES-1:0];
          idx_d   = '0;
          found_d = 1'b0;
          eq_d    = 1'b0;
          pos_d   = used_q;
          if (in_data_i.func == FUNC_CLEAR) begin
            used_d = '0;
            pos_d  = '0;
            res_d  = pack_res(ST_CLEARED, '0, '0, '0);
          end else if (sp_bad) begin
            res_d = pack_res(ST_PRESENT, '0, used_q, '0);
          end
        end
      end
      S_SCAN_RD: rd_addr = idx_q[IW-1:0];
      S_SCAN_CHK: begin
        idx_d = idx_inc;
        if (hit) begin
          res_d = pack_res(ST_PRESENT, idx_q, used_q, rd_mask_q);
        end else if (!found_q && cmp_ge) begin
          found_d   = 1'b1;
          pos_d     = idx_q;
          eq_d      = cmp_eq;
          posmask_d = rd_mask_q;
        end
      end
      S_DECIDE: begin
        idx_d = used_q;
        priority if (found_q && eq_q) begin
          wr_en   = 1'b1;
          wr_mask = join_mask;
          res_d   = pack_res(ST_JOIN, pos_q, used_q, join_mask);
        end else if (tbl_full) begin
          res_d = pack_res(ST_FULL, '0, used_q, '0);
        end else begin
          res_d = res_q;
        end
      end
      S_SH_RD: rd_addr = idx_dec[IW-1:0];
      S_SH_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_q[IW-1:0];
        wr_key  = rd_key_q;
        wr_mask = rd_mask_q;
        idx_d   = idx_dec;
      end
      S_INS: begin
        wr_en  = 1'b1;
        used_d = used_q + CW'(1);
        res_d  = pack_res(ST_NEW, pos_q, used_q + CW'(1), bit_q);
      end
      S_FIN: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      found_q     <= 1'b0;
      eq_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      found_q     <= found_d;
      eq_q        <= eq_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    bit_q     <= bit_d;
    posmask_q <= posmask_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr]  <= wr_key;
      mask_mem[wr_addr] <= wr_mask;
    end
    rd_key_q  <= key_mem[rd_addr];
    rd_mask_q <= mask_mem[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= LEVELS)
    else $error("level count beyond table depth");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= used_q)
    else $error("insert position beyond level count");

  a_wr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (32'(wr_addr) <= 32'(used_q)))
    else $error("write beyond filled levels");

  a_fin_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |-> (res_q.status <= ST_CLEARED))
    else $error("result with undefined status");

endmodule

`default_nettype wire

[sim/sorted_key_group_table_checker.sv]
// Checker for the sorted key group table: tracks the levels, predicts each result, compares.
module sorted_key_group_table_checker
  import skg_pkg::*;
#(
  parameter int LEVELS  = 16,
  parameter int SPECIES = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  output int        fails_o,
  output int        pending_o
);

  logic signed [31:0] lvl_key [LEVELS];
  logic [63:0]        lvl_mask [LEVELS];
  int                 lvl_used;
  out_item_t          awaited_results [$];
  out_item_t          oldest;

  initial fails_o = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch: %s got %0h, want %0h", $realtime, what, got, want);
    fails_o = fails_o + 1;
  endtask

  function automatic out_item_t file_species(input in_item_t it);
    out_item_t   r;
    logic [63:0] sp_bit;
    int          pos;
    r = '0;
    if (it.func == FUNC_CLEAR) begin
      for (int i = 0; i < LEVELS; i++) lvl_mask[i] = '0;
      lvl_used = 0;
      r.status = ST_CLEARED;
      return r;
    end
    r.level_count = 5'(lvl_used);
    if (int'(it.species_index) >= SPECIES) begin
      r.status = ST_PRESENT;
      return r;
    end
    sp_bit = 64'd1 << it.species_index;
    for (int i = 0; i < lvl_used; i++) begin
      if ((lvl_mask[i] & sp_bit) != '0) begin
        r.status         = ST_PRESENT;
        r.level_position = 4'(i);
        r.level_members  = lvl_mask[i];
        return r;
      end
    end
    pos = lvl_used;
    for (int i = 0; i < lvl_used; i++) begin
      if ($signed(lvl_key[i]) >= $signed(it.key_value)) begin
        pos = i;
        break;
      end
    end
    if (pos < lvl_used && lvl_key[pos] == it.key_value) begin
      lvl_mask[pos]   |= sp_bit;
      r.status         = ST_JOIN;
      r.level_position = 4'(pos);
      r.level_members  = lvl_mask[pos];
      return r;
    end
    if (lvl_used >= LEVELS) begin
      r.status = ST_FULL;
      return r;
    end
    for (int i = lvl_used; i > pos; i--) begin
      lvl_key[i]  = lvl_key[i-1];
      lvl_mask[i] = lvl_mask[i-1];
    end
    lvl_key[pos]     = it.key_value;
    lvl_mask[pos]    = sp_bit;
    lvl_used++;
    r.status         = ST_NEW;
    r.level_position = 4'(pos);
    r.level_count    = 5'(lvl_used);
    r.level_members  = sp_bit;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEVELS; i++) begin
        lvl_key[i]  = '0;
        lvl_mask[i] = '0;
      end
      lvl_used = 0;
      awaited_results.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          report("result beat with nothing awaited", 64'(out_data_i), '0);
        end else begin
          oldest = awaited_results.pop_front();
          if (out_data_i.status != oldest.status)
            report("status", 64'(out_data_i.status), 64'(oldest.status));
          if (out_data_i.level_position != oldest.level_position)
            report("level_position", 64'(out_data_i.level_position),
                   64'(oldest.level_position));
          if (out_data_i.level_count != oldest.level_count)
            report("level_count", 64'(out_data_i.level_count), 64'(oldest.level_count));
          if (out_data_i.level_members != oldest.level_members)
            report("level_members", out_data_i.level_members, oldest.level_members);
        end
      end
      if (in_valid_i && !in_stall_i) awaited_results.push_back(file_species(in_data_i));
      pending_o <= awaited_results.size();
    end
  end

endmodule

[sim/sorted_key_group_table_test.sv]
// Testbench top for the sorted key group table: clock, reset, stimulus and verdict.
module sorted_key_group_table_test;
  import skg_pkg::*;

  localparam int POOL_KEYS   = 24;
  localparam int HOLD_CYCLES = 300;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        check_fails;
  int        check_pending;

  int          idle_pct  = 0;
  int          stall_pct = 0;
  logic        hold_off  = 1'b0;
  logic [31:0] key_pool [POOL_KEYS];

  always #5 clk = ~clk;

  sorted_key_group_table i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  sorted_key_group_table_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fails_o     (check_fails),
    .pending_o   (check_pending)
  );

  // receiver: random stall, or a long hold-off on request
  always begin
    @(posedge clk);
    if (hold_off) begin
      out_stall <= 1'b1;
      for (int n = 1; n < HOLD_CYCLES; n++) @(posedge clk);
      hold_off = 1'b0;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #10_000_000;
    $display("sorted_key_group_table verification failed");
    $finish;
  end

  function automatic in_item_t mk_item(input logic func, input int sp, input logic [31:0] key);
    in_item_t it;
    it.func          = func;
    it.species_index = 6'(sp);
    it.key_value     = key;
    return it;
  endfunction

  function automatic void refill_keys();
    for (int i = 0; i < POOL_KEYS; i++) begin
      case ($urandom_range(3))
        0: key_pool[i] = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
        1: key_pool[i] = 32'(int'($urandom_range(8)) - 4);
        default: key_pool[i] = $urandom;
      endcase
    end
  endfunction

  function automatic in_item_t draw_item();
    logic [31:0] key;
    if ($urandom_range(39) == 0) begin
      refill_keys();
      return mk_item(FUNC_CLEAR, $urandom_range(63), $urandom);
    end
    key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_KEYS-1)] : $urandom;
    return mk_item(FUNC_INSERT, $urandom_range(63), key);
  endfunction

  task automatic send_item(input in_item_t it);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (check_pending != 0) @(posedge clk);
  endtask

  initial begin
    int idle_set [4];
    int stall_set [4];
    idle_set  = '{0, 50, 0, 34};
    stall_set = '{0, 0, 50, 34};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    refill_keys();

    send_item(mk_item(FUNC_CLEAR, 0, 32'h0));
    send_item(mk_item(FUNC_INSERT, 0, 32'h0));
    send_item(mk_item(FUNC_INSERT, 63, 32'h7fff_ffff));
    send_item(mk_item(FUNC_INSERT, 1, 32'h8000_0000));
    send_item(mk_item(FUNC_INSERT, 2, 32'h0));
    send_item(mk_item(FUNC_INSERT, 0, 32'h5));
    send_item(mk_item(FUNC_INSERT, 63, 32'h0));
    send_item(mk_item(FUNC_INSERT, 3, 32'hffff_ffff));
    for (int i = 0; i < 12; i++) send_item(mk_item(FUNC_INSERT, 4 + i, 32'((i + 1) << 16)));
    send_item(mk_item(FUNC_INSERT, 20, 32'h0001_2345));
    send_item(mk_item(FUNC_INSERT, 21, 32'h0));
    send_item(mk_item(FUNC_INSERT, 4, 32'h7));
    send_item(mk_item(FUNC_CLEAR, 63, 32'hffff_ffff));
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_set[p];
      stall_pct = stall_set[p];
      for (int i = 0; i < 410; i++) send_item(draw_item());
      wait_drained();
      if (p == 0) begin
        // long receiver hold-off while the sender keeps offering
        hold_off = 1'b1;
        for (int i = 0; i < 30; i++) send_item(draw_item());
        wait_drained();
      end
    end

    repeat (80) @(posedge clk);
    if (check_fails == 0) begin
      $display("sorted_key_group_table verification clean");
    end else begin
      $display("sorted_key_group_table verification failed");
    end
    $finish;
  end

endmodule
